// ----- rtl/trtp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package trtp_pkg;

    localparam int unsigned HDR_BYTES       = 12;
    localparam int unsigned DEF_QUEUE_DEPTH = 2;
    localparam logic [15:0] MAX_PAYLOAD     = 16'd512;
    localparam logic [7:0]  CRC_MASK_BYTE0  = 8'hDF;
    localparam logic [10:0] POS_MAX         = 11'd2047;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [1:0]  TYPE_CODE_DATA  = 2'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_HDR   = 3'd1,
        ST_HDR_CRC  = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_TR_BAD   = 3'd4,
        ST_LEN_MIS  = 3'd5,
        ST_PAY_CRC  = 3'd6
    } status_t;

    // one queued request: the decoded byte or summary plus the raw check flags
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [4:0]  window;
        logic        truncated;
        logic [1:0]  ptype;
        logic [7:0]  seqnum;
        logic [15:0] length_field;
        logic [31:0] timestamp;
        logic        short_hdr;
        status_t     hdr_err;
        logic        with_payload;
        logic        len_mismatch;
        logic        crc_bad;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/trtp_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface trtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/trtp_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface trtp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [4:0]  window;
    logic        truncated;
    logic [1:0]  ptype;
    logic [7:0]  seqnum;
    logic [15:0] length_field;
    logic [31:0] timestamp;
    logic [2:0]  status;

    modport source (
        output valid, output kind, output payload_byte, output window, output truncated,
        output ptype, output seqnum, output length_field, output timestamp, output status,
        input  ready
    );
    modport sink (
        input  valid, input kind, input payload_byte, input window, input truncated,
        input  ptype, input seqnum, input length_field, input timestamp, input status,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/trtp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trtp_front
    import trtp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    trtp_byte_if.sink          pkt,
    input  wire queue_status_t q_status,
    output logic               push,
    output item_t              push_item
);

    logic [10:0] pos_reg,  pos_next;
    logic [63:0] hdr_reg,  hdr_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [31:0] crc_reg,  crc_next;
    status_t     err_reg,  err_next;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  b0;
    logic [15:0] len;
    logic        tr;
    logic        emit;
    logic        with_payload;
    logic [31:0] rcrc_shift;
    logic [16:0] payload_end;
    logic [16:0] idx_ext;
    logic [11:0] total;

    assign pkt.ready = !q_status.full;
    assign accept    = pkt.valid && !q_status.full;

    always_comb
    begin
        b           = pkt.data_byte;
        b0          = hdr_reg[7:0];
        len         = {hdr_reg[23:16], hdr_reg[31:24]};
        tr          = b0[5];
        rcrc_shift  = {rcrc_reg[23:0], b};
        idx_ext     = {6'd0, pos_reg};
        payload_end = 17'(HDR_BYTES) + {1'b0, len};
        total       = {1'b0, pos_reg} + 12'd1;

        hdr_next  = hdr_reg;
        crc_next  = crc_reg;
        rcrc_next = rcrc_reg;
        err_next  = err_reg;
        emit      = 1'b0;

        // header bytes, then the header CRC and its checks
        if (pos_reg < 11'd8)
        begin
            hdr_next = hdr_reg | (64'(b) << {pos_reg[2:0], 3'b000});
            crc_next = crc32_byte(crc_reg, (pos_reg == 11'd0) ? (b & CRC_MASK_BYTE0) : b);
        end
        else if (pos_reg < 11'(HDR_BYTES))
        begin
            rcrc_next = rcrc_shift;
            if (pos_reg == 11'(HDR_BYTES - 1))
            begin
                if (~crc_reg != rcrc_shift)
                    err_next = ST_HDR_CRC;
                else if (len > MAX_PAYLOAD)
                    err_next = ST_TOO_LONG;
                else if (tr && (b0[7:6] != TYPE_CODE_DATA))
                    err_next = ST_TR_BAD;
                crc_next  = CRC_INIT;
                rcrc_next = '0;
            end
        end

        with_payload = !tr && (len != 16'd0) && (err_next == ST_OK);

        // payload bytes, then the payload CRC
        if ((pos_reg >= 11'(HDR_BYTES)) && with_payload)
        begin
            if (idx_ext < payload_end)
            begin
                crc_next = crc32_byte(crc_reg, b);
                emit     = 1'b1;
            end
            else if (idx_ext < payload_end + 17'd4)
            begin
                rcrc_next = rcrc_shift;
            end
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 11'd1 : pos_reg;

        push_item.kind         = pkt.last;
        push_item.payload_byte = b;
        push_item.window       = b0[4:0];
        push_item.truncated    = tr;
        push_item.ptype        = b0[7:6];
        push_item.seqnum       = hdr_next[15:8];
        push_item.length_field = len;
        push_item.timestamp    = hdr_next[63:32];
        push_item.short_hdr    = pos_reg < 11'(HDR_BYTES - 1);
        push_item.hdr_err      = err_next;
        push_item.with_payload = with_payload;
        push_item.len_mismatch = {5'd0, total} != (payload_end + 17'd4);
        push_item.crc_bad      = ~crc_next != rcrc_next;

        push = accept && (pkt.last || emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            rcrc_reg <= '0;
            crc_reg  <= CRC_INIT;
            err_reg  <= ST_OK;
        end
        else if (accept)
        begin
            if (pkt.last)
            begin
                // start over for the next packet
                pos_reg  <= '0;
                hdr_reg  <= '0;
                rcrc_reg <= '0;
                crc_reg  <= CRC_INIT;
                err_reg  <= ST_OK;
            end
            else
            begin
                pos_reg  <= pos_next;
                hdr_reg  <= hdr_next;
                rcrc_reg <= rcrc_next;
                crc_reg  <= crc_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/trtp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trtp_queue
    import trtp_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire item_t   wr_item,
    input  wire logic    pop,
    output item_t        rd_item,
    output queue_status_t status
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t              slot_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_item      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/trtp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trtp_back
    import trtp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire item_t         item,
    input  wire queue_status_t q_status,
    output logic               pop,
    trtp_result_if.source      result
);

    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  payload_reg;
    logic [4:0]  window_reg;
    logic        truncated_reg;
    logic [1:0]  ptype_reg;
    logic [7:0]  seqnum_reg;
    logic [15:0] length_reg;
    logic [31:0] timestamp_reg;
    status_t     status_reg;

    status_t     status_next;
    logic        summary;

    assign pop     = !q_status.empty && (!valid_reg || result.ready);
    assign summary = item.kind;

    // first failure wins
    always_comb
    begin
        if (item.short_hdr)
            status_next = ST_NO_HDR;
        else if (item.hdr_err != ST_OK)
            status_next = item.hdr_err;
        else if (item.with_payload && item.len_mismatch)
            status_next = ST_LEN_MIS;
        else if (item.with_payload && item.crc_bad)
            status_next = ST_PAY_CRC;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg      <= summary;
            payload_reg   <= summary ? 8'd0  : item.payload_byte;
            window_reg    <= summary ? item.window       : 5'd0;
            truncated_reg <= summary ? item.truncated    : 1'b0;
            ptype_reg     <= summary ? item.ptype        : 2'd0;
            seqnum_reg    <= summary ? item.seqnum       : 8'd0;
            length_reg    <= summary ? item.length_field : 16'd0;
            timestamp_reg <= summary ? item.timestamp    : 32'd0;
            status_reg    <= summary ? status_next       : ST_OK;
        end
    end

    assign result.valid        = valid_reg;
    assign result.kind         = kind_reg;
    assign result.payload_byte = payload_reg;
    assign result.window       = window_reg;
    assign result.truncated    = truncated_reg;
    assign result.ptype        = ptype_reg;
    assign result.seqnum       = seqnum_reg;
    assign result.length_field = length_reg;
    assign result.timestamp    = timestamp_reg;
    assign result.status       = status_reg;

endmodule

`default_nettype wire

// ----- rtl/trtp_packet_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming packet decoder: takes one packet byte per cycle on pkt while the queue is not
// full, with last marking the final byte, and returns a request on result for every payload
// byte (kind 0) and one summary (kind 1) at the last byte, carrying the decoded header and a
// status code. The header CRC and the payload CRC advance one byte per cycle in the front
// decoder while bytes are accepted. Results pass through a QUEUE_DEPTH-entry queue and an
// output register, so input keeps flowing at one byte per cycle while result is stalled
// until the queue is full. Each result goes into the queue, then into the output register.
module trtp_packet_decoder_top
    import trtp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    trtp_byte_if.sink     pkt,
    trtp_result_if.source result
);

    logic          push;
    item_t         push_item;
    logic          pop;
    item_t         head_item;
    queue_status_t q_status;

    trtp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    trtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (head_item),
        .status  (q_status)
    );

    trtp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (head_item),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

// ----- rtl/trtp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trtp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pkt_valid,
    input wire logic        pkt_ready,
    input wire logic        pkt_last,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        res_kind,
    input wire logic [7:0]  res_payload_byte,
    input wire logic [4:0]  res_window,
    input wire logic        res_truncated,
    input wire logic [1:0]  res_ptype,
    input wire logic [7:0]  res_seqnum,
    input wire logic [15:0] res_length_field,
    input wire logic [31:0] res_timestamp,
    input wire logic [2:0]  res_status
);

    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (pkt_valid && pkt_ready)
            seen_reg <= 1'b1;
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_payload_byte) && $stable(res_window) && $stable(res_truncated)
            && $stable(res_ptype) && $stable(res_seqnum) && $stable(res_length_field)
            && $stable(res_timestamp) && $stable(res_status))
        else $error("result request changed while stalled");

    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_ready |-> res_valid)
        else $error("input stalled with no result waiting");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> seen_reg)
        else $error("result offered before any byte was taken");

    a_summary_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready && pkt_last |-> ##2 res_valid)
        else $error("summary did not reach the output");

endmodule

bind trtp_packet_decoder_top trtp_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pkt_valid        (pkt.valid),
    .pkt_ready        (pkt.ready),
    .pkt_last         (pkt.last),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_kind         (result.kind),
    .res_payload_byte (result.payload_byte),
    .res_window       (result.window),
    .res_truncated    (result.truncated),
    .res_ptype        (result.ptype),
    .res_seqnum       (result.seqnum),
    .res_length_field (result.length_field),
    .res_timestamp    (result.timestamp),
    .res_status       (result.status)
);

`default_nettype wire
